// ===== rtl/nscs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package nscs_pkg;

  // Width of the internal byte position counter.
  localparam int OFFSET_BITS = 24;
  localparam int FIELD_BITS = 24;

  localparam logic [23:0] WINDOW_ONES = 24'hffffff;
  localparam logic [23:0] SC_PREFIX = 24'h000001;

  // Result queue: one header byte can produce two results.
  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  typedef logic [OFFSET_BITS-1:0] offset_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [23:0] nal_start;
    logic [4:0]  nal_type;
    logic        forbidden_bit;
    logic [23:0] nal_length;
    logic        final_nal;
    logic        overflow;
    logic        last_in_run;
  } out_item_t;

  // Zero-extends or truncates an offset to the 24-bit result fields.
  function automatic logic [FIELD_BITS-1:0] to_field(input offset_t v);
    logic [OFFSET_BITS+FIELD_BITS-1:0] wide;
    wide = {{FIELD_BITS{1'b0}}, v};
    return wide[FIELD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nal_start_code_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none

// H.264 Annex B start code scanner.
// Bytes of a buffer enter on the in channel, one per transfer, with
// end_of_buffer set on the last byte. Each NAL found is reported on the out
// channel with its start offset, type, forbidden bit and length; the last NAL
// of a buffer is reported at the buffer end with final_nal set.
// The cfg channel writes reject_forbidden; write it only while the block is
// idle. cfg_ready is always high.
// A result enters the result queue when its byte is taken and shows on out
// once the results ahead of it have left. Throughput is one byte per cycle;
// a header byte that is also the buffer end yields two results if an earlier
// NAL is open, and they leave in two consecutive out transfers. A four-entry
// result queue sits between the scanner and the out port, so bytes keep
// flowing while the receiver holds off out_ready, until the queue has fewer
// than two free entries. Reset (synchronous, active high) clears the
// scanner, empties the queue and sets reject_forbidden to zero.
module nal_start_code_scanner (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire                      cfg_data,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire nscs_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output nscs_pkg::out_item_t      out_data
);

  logic        reject_forbidden;
  logic [23:0] byte_window;
  nscs_pkg::offset_t byte_position;
  nscs_pkg::offset_t open_start;
  logic [4:0]  open_type;
  logic        open_forbidden;
  logic        open_valid;
  logic        saturated;

  nscs_pkg::out_item_t queue [nscs_pkg::QDEPTH];
  logic [nscs_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [nscs_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [nscs_pkg::QCNT_BITS-1:0] count;

  logic in_acc;
  logic out_acc;

  logic              match;
  nscs_pkg::offset_t sc;
  nscs_pkg::offset_t len_close;
  nscs_pkg::offset_t endp;
  nscs_pkg::offset_t len_final;
  logic              close_prev;
  nscs_pkg::offset_t open_start_next;
  logic [4:0]        open_type_next;
  logic              open_forbidden_next;
  logic              open_valid_next;
  logic              close_final;
  nscs_pkg::out_item_t res_close;
  nscs_pkg::out_item_t res_final;
  nscs_pkg::out_item_t res_first;
  logic [1:0]        push_cnt;
  logic [nscs_pkg::QCNT_BITS-1:0] count_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = count <= nscs_pkg::QCNT_BITS'(nscs_pkg::QDEPTH - 2);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = count != '0;
  assign out_data  = queue[rd_ptr];
  assign out_acc   = out_valid && out_ready;

  always_comb begin
    match = (byte_window == nscs_pkg::SC_PREFIX) &&
            !(reject_forbidden && in_data.data_byte[7]);
    sc = (byte_position >= nscs_pkg::offset_t'(3)) ?
         byte_position - nscs_pkg::offset_t'(3) : '0;
    len_close = (sc >= open_start) ? sc - open_start : '0;
    close_prev = match && open_valid;

    open_start_next     = match ? sc : open_start;
    open_type_next      = match ? in_data.data_byte[4:0] : open_type;
    open_forbidden_next = match ? in_data.data_byte[7] : open_forbidden;
    open_valid_next     = match || open_valid;

    // The end position stops at the counter's maximum.
    endp = (byte_position == '1) ? byte_position
                                 : byte_position + nscs_pkg::offset_t'(1);
    len_final = (endp >= open_start_next) ? endp - open_start_next : '0;
    close_final = in_data.end_of_buffer && open_valid_next;

    res_close.nal_start     = nscs_pkg::to_field(open_start);
    res_close.nal_type      = open_type;
    res_close.forbidden_bit = open_forbidden;
    res_close.nal_length    = nscs_pkg::to_field(len_close);
    res_close.final_nal     = 1'b0;
    res_close.overflow      = saturated;
    res_close.last_in_run   = !close_final;

    res_final.nal_start     = nscs_pkg::to_field(open_start_next);
    res_final.nal_type      = open_type_next;
    res_final.forbidden_bit = open_forbidden_next;
    res_final.nal_length    = nscs_pkg::to_field(len_final);
    res_final.final_nal     = 1'b1;
    res_final.overflow      = saturated;
    res_final.last_in_run   = 1'b1;

    res_first = close_prev ? res_close : res_final;
    push_cnt  = in_acc ? {1'b0, close_prev} + {1'b0, close_final} : 2'd0;
    count_next = count + nscs_pkg::QCNT_BITS'(push_cnt)
                 - nscs_pkg::QCNT_BITS'(out_acc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reject_forbidden <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      reject_forbidden <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_window    <= nscs_pkg::WINDOW_ONES;
      byte_position  <= '0;
      open_start     <= '0;
      open_type      <= '0;
      open_forbidden <= 1'b0;
      open_valid     <= 1'b0;
      saturated      <= 1'b0;
    end else if (in_acc) begin
      if (in_data.end_of_buffer) begin
        byte_window    <= nscs_pkg::WINDOW_ONES;
        byte_position  <= '0;
        open_start     <= '0;
        open_type      <= '0;
        open_forbidden <= 1'b0;
        open_valid     <= 1'b0;
        saturated      <= 1'b0;
      end else begin
        byte_window    <= {byte_window[15:0], in_data.data_byte};
        open_start     <= open_start_next;
        open_type      <= open_type_next;
        open_forbidden <= open_forbidden_next;
        open_valid     <= open_valid_next;
        if (byte_position == '1) begin
          saturated <= 1'b1;
        end else begin
          byte_position <= byte_position + nscs_pkg::offset_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      queue[wr_ptr] <= res_first;
    end
    if (push_cnt == 2'd2) begin
      queue[wr_ptr + nscs_pkg::QPTR_BITS'(1)] <= res_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + nscs_pkg::QPTR_BITS'(push_cnt);
      if (out_acc) begin
        rd_ptr <= rd_ptr + nscs_pkg::QPTR_BITS'(1);
      end
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= nscs_pkg::QCNT_BITS'(nscs_pkg::QDEPTH))
    else $error("result queue count exceeds its depth");

  a_buffer_restart: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_data.end_of_buffer |=>
      !open_valid && byte_position == '0 && byte_window == nscs_pkg::WINDOW_ONES)
    else $error("scanner state not restarted after buffer end");

  a_position_step: assert property (@(posedge clk) disable iff (rst)
    in_acc && !in_data.end_of_buffer && !saturated && byte_position != '1 |=>
      byte_position == $past(byte_position) + nscs_pkg::offset_t'(1))
    else $error("byte position did not advance by one");

  a_run_complete: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last_in_run |-> count >= nscs_pkg::QCNT_BITS'(2))
    else $error("first result of a pair has no partner queued");

endmodule

`default_nettype wire
